### hw/rtl/rsf_pkg.sv
// Shared types and constants of the receive sequence filter.
`default_nettype none
package rsf_pkg;

  localparam int unsigned NODE_W = 5;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned WORD_W = 16;

  // Wrap window for the older-id test.
  localparam logic [SEQ_W-1:0] WRAP_WINDOW = 16'd100;
  localparam logic [SEQ_W-1:0] WRAP_HIGH   = 16'd65436;

  // Payload size that marks a connected-mask update.
  localparam logic [SIZE_W-1:0] MASK_SIZE = 11'd2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [WORD_W-1:0] word_t;

  // Decision for one sub-packet header.
  typedef struct packed {
    logic accept;    // expected id, state advances
    logic older;     // older id inside the window, ack only
    logic mask_upd;  // accepted two-byte payload
  } verdict_t;

endpackage
`default_nettype wire

### hw/rtl/receive_sequence_filter_top.sv
// Top level of the receive sequence filter: input stage, decision and result register.
//
//   channel | ports                                             | direction
//   in      | in_valid, in_stall, in_source_node .. in_last_in_frame | header in
//   out     | out_valid, out_stall, out_deliver .. out_ack_seq  | verdict/ack out
//
// One item per cycle when out_stall is low; input stage, then result register.
// The per-node table is read and written in the same cycle as the decision, so
// consecutive items from the same node see each other's updates.
// Synchronous active-low reset clears the node table and the pending ack.
// A stalled result holds the input stage, which then stalls the input channel.
`default_nettype none
module receive_sequence_filter_top #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rsf_pkg::node_t in_source_node,
  input  wire rsf_pkg::seq_t  in_seq_id,
  input  wire rsf_pkg::size_t in_payload_size,
  input  wire rsf_pkg::word_t in_payload_word,
  input  wire logic           in_last_in_frame,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_deliver,
  output logic                out_mask_valid,
  output rsf_pkg::word_t      out_mask_value,
  output logic                out_ack_valid,
  output rsf_pkg::node_t      out_ack_target,
  output rsf_pkg::seq_t       out_ack_seq
);
  import rsf_pkg::*;

  localparam int unsigned IDX_W = $clog2(NODE_COUNT + 1);

  // Input stage
  logic  s1_valid_r;
  node_t s1_node_r;
  seq_t  s1_seq_r;
  size_t s1_size_r;
  word_t s1_word_r;
  logic  s1_last_r;

  // Result stage
  logic  out_valid_r;
  logic  deliver_r, mask_valid_r, ack_valid_r;
  word_t mask_value_r;
  node_t ack_target_r;
  seq_t  ack_seq_r;

  seq_t  pending_ack_r, pending_ack_nxt;

  logic     res_ready, s1_fire, in_fire, in_range;
  seq_t     last_seq, pend_mid;
  verdict_t verdict;

  assign res_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && res_ready;
  assign in_stall  = s1_valid_r && !res_ready;
  assign in_fire   = in_valid && !in_stall;
  assign in_range  = s1_node_r <= NODE_W'(NODE_COUNT);

  rsf_node_table #(.NODE_COUNT(NODE_COUNT)) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (s1_node_r[IDX_W-1:0]),
    .rd_seq (last_seq),
    .wr_en  (s1_fire && verdict.accept),
    .wr_idx (s1_node_r[IDX_W-1:0]),
    .wr_seq (s1_seq_r)
  );

  rsf_judge u_judge (
    .in_range     (in_range),
    .seq_id       (s1_seq_r),
    .last_seq     (last_seq),
    .payload_size (s1_size_r),
    .verdict      (verdict)
  );

  always_comb begin
    pend_mid        = (verdict.accept || verdict.older) ? s1_seq_r : pending_ack_r;
    // Clear the owed ack at frame end
    pending_ack_nxt = s1_last_r ? '0 : pend_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      pending_ack_r <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r   <= 1'b1;
        pending_ack_r <= pending_ack_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_node_r <= in_source_node;
      s1_seq_r  <= in_seq_id;
      s1_size_r <= in_payload_size;
      s1_word_r <= in_payload_word;
      s1_last_r <= in_last_in_frame;
    end
    if (s1_fire) begin
      deliver_r    <= verdict.accept && !verdict.mask_upd;
      mask_valid_r <= verdict.mask_upd;
      mask_value_r <= verdict.mask_upd ? s1_word_r : '0;
      ack_valid_r  <= s1_last_r && (pend_mid != '0);
      ack_target_r <= (s1_last_r && (pend_mid != '0)) ? s1_node_r : '0;
      ack_seq_r    <= (s1_last_r && (pend_mid != '0)) ? pend_mid : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_deliver    = deliver_r;
  assign out_mask_valid = mask_valid_r;
  assign out_mask_value = mask_value_r;
  assign out_ack_valid  = ack_valid_r;
  assign out_ack_target = ack_target_r;
  assign out_ack_seq    = ack_seq_r;

  a_excl_deliver_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(deliver_r && mask_valid_r))
    else $error("deliver and mask update both set");

  a_ack_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ack_valid_r) |-> (ack_seq_r != '0))
    else $error("ack carries sequence zero");

  a_no_ack_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ack_valid_r) |-> (ack_seq_r == '0 && ack_target_r == '0))
    else $error("ack fields set without ack");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (pending_ack_r == '0))
    else $error("pending ack survives frame end");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s1_valid_r) |-> in_stall)
    else $error("input taken while both stages are full");

endmodule
`default_nettype wire

### hw/rtl/rsf_node_table.sv
// Per-node register file holding the last accepted sequence id.
`default_nettype none
module rsf_node_table #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [$clog2(NODE_COUNT+1)-1:0] rd_idx,
  output rsf_pkg::seq_t                    rd_seq,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(NODE_COUNT+1)-1:0] wr_idx,
  input  wire rsf_pkg::seq_t               wr_seq
);
  import rsf_pkg::*;

  localparam int unsigned DEPTH = NODE_COUNT + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  seq_t last_seq_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        last_seq_r[i] <= '0;
      end
    end else if (wr_en) begin
      last_seq_r[wr_idx] <= wr_seq;
    end
  end

  // Guard indexes past the table; the caller discards those anyway.
  assign rd_seq = (rd_idx <= IDX_W'(NODE_COUNT)) ? last_seq_r[rd_idx] : '0;

endmodule
`default_nettype wire

### hw/rtl/rsf_judge.sv
// Sequence check: expected-id match and wrap-window older test.
`default_nettype none
module rsf_judge (
  input  wire logic           in_range,
  input  wire rsf_pkg::seq_t  seq_id,
  input  wire rsf_pkg::seq_t  last_seq,
  input  wire rsf_pkg::size_t payload_size,
  output rsf_pkg::verdict_t   verdict
);
  import rsf_pkg::*;

  seq_t expected;
  seq_t incr;
  logic older_raw;

  always_comb begin
    incr     = last_seq + 16'd1;
    // Skip zero on wrap
    expected = (incr == '0) ? 16'd1 : incr;

    if (expected < WRAP_WINDOW) begin
      older_raw = (seq_id < expected) || (seq_id > WRAP_HIGH);
    end else if (expected > WRAP_HIGH) begin
      older_raw = (seq_id < expected) && (seq_id > WRAP_WINDOW);
    end else begin
      older_raw = seq_id < expected;
    end

    verdict.accept   = in_range && (seq_id == expected);
    verdict.older    = in_range && (seq_id != expected) && older_raw;
    verdict.mask_upd = verdict.accept && (payload_size == MASK_SIZE);
  end

endmodule
`default_nettype wire
